@@ hdl/cache_budget_limit_controller_unit_macros.svh @@
// Assertion helpers used by the checker file.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef CACHE_BUDGET_LIMIT_CONTROLLER_UNIT_MACROS_SVH
`define CACHE_BUDGET_LIMIT_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBLC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define CBLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cblc_pkg.sv @@
package cblc_pkg;

  // Every size in the budget is this wide, and sat_add saturates a sum at its top.
  localparam int unsigned SIZE_BITS = 48;
  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned RECORD_OVERHEAD = 256;
  localparam int unsigned MIN_LIMIT = 16384;
  localparam int unsigned GROW_SHIFT = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [SIZE_BITS-1:0] size_t;

  localparam size_t OVERHEAD_S = size_t'(RECORD_OVERHEAD);
  localparam size_t MIN_LIMIT_S = size_t'(MIN_LIMIT);

  localparam size_t RST_FIXED_SIZE = '0;
  localparam size_t RST_MAX_SIZE = '1;
  localparam size_t RST_INITIAL_LIMIT = size_t'(16384);
  localparam size_t RST_INITIAL_TABLE = '0;
  localparam size_t RST_DESERVED =
    RST_INITIAL_LIMIT + RST_FIXED_SIZE + RST_INITIAL_TABLE + OVERHEAD_S;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_SIZE    = 2'd0,
    CFG_MAX_SIZE      = 2'd1,
    CFG_INITIAL_LIMIT = 2'd2,
    CFG_INITIAL_TABLE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FN_ADJ_USAGE    = 3'd0,
    FN_ADJ_LIMITS   = 3'd1,
    FN_ADJ_DESERVED = 3'd2,
    FN_NEW_LIMIT    = 3'd3,
    FN_MIGRATE_CHK  = 3'd4,
    FN_CHANGE_TABLE = 3'd5
  } func_t;

  typedef struct packed {
    size_t fixed_size;
    size_t max_size;
    size_t initial_limit;
    size_t initial_table;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                   func;
    logic signed [FIELD_BITS-1:0] usage_change;
    logic [FIELD_BITS-1:0]        soft_request;
    logic [FIELD_BITS-1:0]        hard_request;
    logic [FIELD_BITS-1:0]        deserved_request;
    logic [FIELD_BITS-1:0]        table_request;
  } in_req_t;

  typedef struct packed {
    logic                  accepted;
    logic [FIELD_BITS-1:0] value;
  } out_rsp_t;

  function automatic size_t sat_add(size_t a, size_t b);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_BITS] ? '1 : s[SIZE_BITS-1:0];
  endfunction

  function automatic size_t min_size(size_t a, size_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

@@ hdl/cblc_cfg_regs.sv @@
module cblc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           busy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cblc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cblc_pkg::SIZE_BITS-1:0] cfg_data,
  output cblc_pkg::cfg_t                 cfg,
  output logic                           reload
);

  cblc_pkg::cfg_t cfg_r, cfg_nxt;
  logic           reload_r, reload_nxt;
  logic           wr;

  assign cfg_ready = !busy;
  assign wr        = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt    = cfg_r;
    reload_nxt = wr;
    if (wr) begin
      unique case (cblc_pkg::cfg_reg_t'(cfg_index))
        cblc_pkg::CFG_FIXED_SIZE:    cfg_nxt.fixed_size    = cfg_data;
        cblc_pkg::CFG_MAX_SIZE:      cfg_nxt.max_size      = cfg_data;
        cblc_pkg::CFG_INITIAL_LIMIT: cfg_nxt.initial_limit = cfg_data;
        cblc_pkg::CFG_INITIAL_TABLE: cfg_nxt.initial_table = cfg_data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  // The reload strobe is registered from a write, so the start state reloads from the stored values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fixed_size    <= cblc_pkg::RST_FIXED_SIZE;
      cfg_r.max_size      <= cblc_pkg::RST_MAX_SIZE;
      cfg_r.initial_limit <= cblc_pkg::RST_INITIAL_LIMIT;
      cfg_r.initial_table <= cblc_pkg::RST_INITIAL_TABLE;
      reload_r            <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      reload_r <= reload_nxt;
    end
  end

  assign cfg    = cfg_r;
  assign reload = reload_r;

endmodule

@@ hdl/cblc_budget_core.sv @@
module cblc_budget_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  cblc_pkg::in_req_t  req,
  input  cblc_pkg::cfg_t     cfg,
  input  logic               reload,
  output cblc_pkg::out_rsp_t rsp
);

  cblc_pkg::size_t usage_r, usage_nxt;
  cblc_pkg::size_t soft_r, soft_nxt;
  cblc_pkg::size_t hard_r, hard_nxt;
  cblc_pkg::size_t table_r, table_nxt;
  cblc_pkg::size_t deserved_r, deserved_nxt;

  cblc_pkg::size_t base, cap, chg_u, mag, desired, grow, suggest, need, des_clamp;
  cblc_pkg::size_t soft_q, hard_q, mn;
  logic            neg, under, adj_ok, lim_ok, fit_ok;

  always_comb begin
    mn     = cblc_pkg::MIN_LIMIT_S;
    base   = cblc_pkg::sat_add(cblc_pkg::sat_add(table_r, cfg.fixed_size),
                               cblc_pkg::OVERHEAD_S);
    cap    = cblc_pkg::min_size(deserved_r, cfg.max_size);

    // Usage change: a decrease below zero is refused.
    chg_u   = req.usage_change;
    neg     = chg_u[cblc_pkg::SIZE_BITS-1];
    mag     = (~chg_u) + cblc_pkg::size_t'(1);
    under   = neg && (mag > usage_r);
    if (neg) begin
      desired = under ? usage_r : (usage_r - mag);
    end else begin
      desired = cblc_pkg::sat_add(usage_r, chg_u);
    end
    adj_ok = !under && !(desired > hard_r) && !((usage_r <= soft_r) && (desired > soft_r));

    // Limit change: approved when any of the shrink or grow rules holds.
    soft_q = req.soft_request;
    hard_q = req.hard_request;
    lim_ok = ((soft_q == mn) && (hard_q == hard_r)) ||
             ((soft_q == mn) && (hard_q == mn) && (usage_r <= hard_q)) ||
             ((hard_q == hard_r) && (soft_q < hard_q) &&
              (cblc_pkg::sat_add(soft_q, base) <= cap)) ||
             ((soft_q == soft_r) && (soft_q == hard_q) && (usage_r <= hard_q)) ||
             ((soft_q == hard_q) && (usage_r <= hard_q) &&
              (cblc_pkg::sat_add(hard_q, base) <= cap));

    des_clamp = cblc_pkg::min_size(req.deserved_request, cfg.max_size);

    if (|hard_r[cblc_pkg::SIZE_BITS-1 -: cblc_pkg::GROW_SHIFT]) begin
      grow = '1;
    end else begin
      grow = hard_r << cblc_pkg::GROW_SHIFT;
    end
    if (cblc_pkg::sat_add(mn, base) >= deserved_r) begin
      suggest = mn;
    end else begin
      suggest = cblc_pkg::min_size(deserved_r - base, grow);
    end

    need   = cblc_pkg::sat_add(cblc_pkg::sat_add(cblc_pkg::sat_add(hard_r, cfg.fixed_size),
                               req.table_request), cblc_pkg::OVERHEAD_S);
    fit_ok = (need <= cap);
  end

  always_comb begin
    usage_nxt    = usage_r;
    soft_nxt     = soft_r;
    hard_nxt     = hard_r;
    table_nxt    = table_r;
    deserved_nxt = deserved_r;
    rsp.accepted = 1'b0;
    rsp.value    = usage_r;
    unique case (req.func)
      cblc_pkg::FN_ADJ_USAGE: begin
        rsp.accepted = adj_ok;
        if (adj_ok) begin
          usage_nxt = desired;
          rsp.value = desired;
        end
      end
      cblc_pkg::FN_ADJ_LIMITS: begin
        rsp.accepted = lim_ok;
        if (lim_ok) begin
          soft_nxt = soft_q;
          hard_nxt = hard_q;
        end
      end
      cblc_pkg::FN_ADJ_DESERVED: begin
        rsp.accepted = 1'b1;
        rsp.value    = des_clamp;
        deserved_nxt = des_clamp;
      end
      cblc_pkg::FN_NEW_LIMIT: begin
        rsp.accepted = 1'b1;
        rsp.value    = suggest;
      end
      cblc_pkg::FN_MIGRATE_CHK: begin
        rsp.accepted = fit_ok;
      end
      cblc_pkg::FN_CHANGE_TABLE: begin
        rsp.accepted = 1'b1;
        table_nxt    = req.table_request;
      end
      default: begin
        rsp.accepted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usage_r    <= '0;
      soft_r     <= cblc_pkg::RST_INITIAL_LIMIT;
      hard_r     <= cblc_pkg::RST_INITIAL_LIMIT;
      table_r    <= cblc_pkg::RST_INITIAL_TABLE;
      deserved_r <= cblc_pkg::RST_DESERVED;
    end else if (reload) begin
      usage_r    <= '0;
      soft_r     <= cfg.initial_limit;
      hard_r     <= cfg.initial_limit;
      table_r    <= cfg.initial_table;
      deserved_r <= cblc_pkg::sat_add(cblc_pkg::sat_add(cblc_pkg::sat_add(
                      cfg.initial_limit, cfg.fixed_size), cfg.initial_table),
                      cblc_pkg::OVERHEAD_S);
    end else if (fire) begin
      usage_r    <= usage_nxt;
      soft_r     <= soft_nxt;
      hard_r     <= hard_nxt;
      table_r    <= table_nxt;
      deserved_r <= deserved_nxt;
    end
  end

endmodule

@@ hdl/cache_budget_limit_controller_unit.sv @@
// An accepted request is held in stage one, its result in the output register.
// Throughput: one request per cycle unless the output stalls or a reload is under way;
// the budget state is read and updated by one pass of adders and comparators between
// the request register and the result register. A configuration write stalls the
// input for one cycle while the start state reloads. Reset (rst_n low, synchronous)
// empties both stages and loads the default registers and the derived start state.
module cache_budget_limit_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cblc_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cblc_pkg::out_rsp_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cblc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cblc_pkg::SIZE_BITS-1:0] cfg_data
);

  // Stage one holds the accepted request; the output register holds its result.
  logic               s1_valid_r, s1_valid_nxt;
  cblc_pkg::in_req_t  s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  cblc_pkg::out_rsp_t out_data_r;

  logic               out_ready;
  logic               s1_fire;
  logic               in_fire;
  logic               reload;
  cblc_pkg::cfg_t     cfg;
  cblc_pkg::out_rsp_t rsp;

  // The output register can take a new result when it is empty or being drained.
  // Because the request in stage one moves on in that same cycle, a new request can
  // enter behind it, so the two stages together sustain one request per cycle while
  // the consumer does not stall.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;

  // The input is held off while stage one cannot drain, and for the one cycle in
  // which a configuration write reloads the budget state.
  assign in_stall  = (s1_valid_r && !out_ready) || reload;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= rsp;
    end
  end

  // Configuration registers; writes are taken only while no request is in stage one
  // and none is being offered, so a reload never races a request.
  cblc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (s1_valid_r || in_valid),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .reload    (reload)
  );

  // Budget state and the single-pass evaluation of the request in stage one. The
  // state commits in the same edge that moves the result out, so the next request
  // always sees the effect of the one before it.
  cblc_budget_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .req    (s1_data_r),
    .cfg    (cfg),
    .reload (reload),
    .rsp    (rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/cblc_checker.sv @@
`include "cache_budget_limit_controller_unit_macros.svh"

module cblc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cblc_pkg::out_rsp_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // A stalled result stays on the port unchanged.
  `CBLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result dropped or changed")

  // An accepted request reaches the output when the output is not stalled while it sits in stage one.
  `CBLC_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid, "result missing two cycles after request")

  // The input only stalls behind a pending result or right after a configuration write.
  `CBLC_ASSERT_SAME(a_stall_cause, in_stall, out_valid || $past(cfg_valid && cfg_ready), "input stalled without cause")

endmodule

bind cache_budget_limit_controller_unit cblc_checker u_cblc_checker (.*);
